>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds in this cycle -> consequent holds in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Antecedent holds in this cycle -> consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/hdf_pkg.sv
// ----------------------------------------------------------------------------
// hdf_pkg
// Shared types, constants and the hex digit lookup for the hex dump formatter.
// ----------------------------------------------------------------------------
package hdf_pkg;

	// Address width kept in the address counter (16..32)
	localparam int ADDR_BITS   = 32;
	// Printed address is always this many hex digits
	localparam int DUMP_DIGITS = 8;
	localparam int DIG_BITS    = $clog2(DUMP_DIGITS);
	localparam int WORD_BITS   = 4 * DUMP_DIGITS;

	// Queue between classifier and sequencer
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	// Spaces of padding: three per skipped byte position, at most 45
	localparam int SPC_BITS    = 6;

	// ASCII codes
	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_X     = 7'h78;
	localparam logic [6:0] CH_COLON = 7'h3a;
	localparam logic [6:0] CH_SPACE = 7'h20;
	localparam logic [6:0] CH_A_LC  = 7'h61;

	// One classified item, as handed from front to back
	typedef struct packed {
		logic                 hdr;      // open a new line before this byte
		logic [ADDR_BITS-1:0] addr;     // address of this byte
		logic [7:0]           data;
		logic                 eol;      // this byte closes its line
		logic                 eod;      // this byte closes the dump
	} hdf_cmd_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic valid;   // head entry present
		logic full;
	} hdf_qstat_t;

	// Character sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ZERO,
		ST_X,
		ST_ADDR,
		ST_COLON,
		ST_PAD,
		ST_SPACE,
		ST_HI,
		ST_LO
	} hdf_state_t;

	// Lowercase hex digit for one nibble
	function automatic logic [6:0] hex_char(input logic [3:0] nib);
		logic [6:0] c;
		if (nib < 4'd10) begin
			c = CH_ZERO + {3'b000, nib};
		end else begin
			c = CH_A_LC + {3'b000, nib - 4'd10};
		end
		return c;
	endfunction

endpackage

>>> rtl/hex_dump_line_formatter.sv
// An item's first character passes the command queue, sequencer state and output register.
// One character per cycle from the back sequencer while out_stall is low. A byte in a line
// gives space and two hex digits, after 0x, address, colon and padding if it opens a line.
// The input side takes a new item every cycle until the 4-entry command queue is full.
// Reset (arst_n low, asynchronous): queue empty, no output valid, address 0, no line open.
// ----------------------------------------------------------------------------
// hex_dump_line_formatter
// Turns a byte stream into hex-dump text: a front classifier, a command queue
// and a character sequencer with a registered output.
// ----------------------------------------------------------------------------
module hex_dump_line_formatter import hdf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic [31:0] start_address,
	input  logic        first_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  character,
	output logic        end_of_line,
	output logic        end_of_dump
);

	hdf_qstat_t qstat;
	hdf_cmd_t   push_cmd;
	hdf_cmd_t   head_cmd;
	logic       push;
	logic       pop;

	// Classifier
	hdf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.start_address (start_address),
		.first_byte    (first_byte),
		.last_byte     (last_byte),
		.qstat         (qstat),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	// Command queue
	hdf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.qstat    (qstat)
	);

	// Character sequencer
	hdf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_cmd    (head_cmd),
		.qstat       (qstat),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.character   (character),
		.end_of_line (end_of_line),
		.end_of_dump (end_of_dump)
	);

endmodule

>>> rtl/hdf_front.sv
// ----------------------------------------------------------------------------
// hdf_front
// Accepts input items, tracks the running address and line state, and turns
// each item into a command for the character sequencer.
// ----------------------------------------------------------------------------
module hdf_front import hdf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic [31:0] start_address,
	input  logic        first_byte,
	input  logic        last_byte,
	input  hdf_qstat_t  qstat,
	output logic        push,
	output hdf_cmd_t    push_cmd
);

	logic [ADDR_BITS-1:0] cur_addr_q;
	logic                 line_open_q;
	logic [ADDR_BITS-1:0] addr_eff;
	logic                 open_eff;

	// Accept whenever the queue has room
	assign in_stall = qstat.full;
	assign push     = in_valid && !qstat.full;

	// A first byte restarts the address and drops any open line
	assign addr_eff = first_byte ? start_address[ADDR_BITS-1:0] : cur_addr_q;
	assign open_eff = first_byte ? 1'b0 : line_open_q;

	// Classify the item
	always_comb begin
		push_cmd.hdr  = !open_eff;
		push_cmd.addr = addr_eff;
		push_cmd.data = data_byte;
		push_cmd.eol  = last_byte || (addr_eff[3:0] == 4'hf);
		push_cmd.eod  = last_byte;
	end

	// Running address and line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_addr_q  <= '0;
			line_open_q <= 1'b0;
		end else if (push) begin
			cur_addr_q  <= addr_eff + 1'b1;
			line_open_q <= !push_cmd.eol;
		end
	end

endmodule

>>> rtl/hdf_queue.sv
// ----------------------------------------------------------------------------
// hdf_queue
// Short command queue that decouples the classifier from the sequencer.
// ----------------------------------------------------------------------------
module hdf_queue import hdf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  hdf_cmd_t   push_cmd,
	input  logic       pop,
	output hdf_cmd_t   head_cmd,
	output hdf_qstat_t qstat
);

	hdf_cmd_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;

	assign qstat.valid = (count_q != '0);
	assign qstat.full  = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign head_cmd    = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/hdf_back.sv
// ----------------------------------------------------------------------------
// hdf_back
// Character sequencer: expands one command into any header, padding and hex
// characters, one per cycle unless stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module hdf_back import hdf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  hdf_cmd_t   head_cmd,
	input  hdf_qstat_t qstat,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] character,
	output logic       end_of_line,
	output logic       end_of_dump
);

	hdf_state_t           state_q, state_d;
	logic [ADDR_BITS-1:0] addr_q;
	logic [7:0]           data_q;
	logic                 eol_q;
	logic                 eod_q;
	logic [DIG_BITS-1:0]  dig_q;
	logic [SPC_BITS-1:0]  spc_q;
	logic                 out_valid_q;
	logic [6:0]           char_q;
	logic                 out_eol_q;
	logic                 out_eod_q;

	logic                 adv;
	logic                 emit;
	logic [6:0]           char_d;
	logic                 eol_d;
	logic                 eod_d;
	logic [WORD_BITS-1:0] base_word;
	logic [3:0]           addr_nib;
	logic [3:0]           head_pad;
	logic [SPC_BITS-1:0]  head_spc;

	// Output register free or being drained
	assign adv  = !out_valid_q || !out_stall;
	assign emit = adv && (state_q != ST_IDLE);

	// Aligned line address, zero-extended to the printed width
	assign base_word = WORD_BITS'(addr_q) & ~WORD_BITS'(4'hf);
	assign addr_nib  = base_word[{dig_q, 2'b00} +: 4];

	// Three spaces per skipped position
	assign head_pad = head_cmd.addr[3:0];
	assign head_spc = ({2'b00, head_pad} << 1) + {2'b00, head_pad};

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, character and queue pop
	always_comb begin
		hdf_state_t nxt;
		nxt    = state_q;
		char_d = CH_SPACE;
		eol_d  = 1'b0;
		eod_d  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				nxt = ST_IDLE;
			end
			ST_ZERO: begin
				char_d = CH_ZERO;
				nxt    = ST_X;
			end
			ST_X: begin
				char_d = CH_X;
				nxt    = ST_ADDR;
			end
			ST_ADDR: begin
				char_d = hex_char(addr_nib);
				nxt    = (dig_q == '0) ? ST_COLON : ST_ADDR;
			end
			ST_COLON: begin
				char_d = CH_COLON;
				nxt    = (spc_q != '0) ? ST_PAD : ST_SPACE;
			end
			ST_PAD: begin
				char_d = CH_SPACE;
				nxt    = (spc_q == SPC_BITS'(1)) ? ST_SPACE : ST_PAD;
			end
			ST_SPACE: begin
				char_d = CH_SPACE;
				nxt    = ST_HI;
			end
			ST_HI: begin
				char_d = hex_char(data_q[7:4]);
				nxt    = ST_LO;
			end
			ST_LO: begin
				char_d = hex_char(data_q[3:0]);
				eol_d  = eol_q;
				eod_d  = eod_q;
				nxt    = ST_IDLE;
			end
			default: begin
				nxt = ST_IDLE;
			end
		endcase

		state_d = emit ? nxt : state_q;

		// Take the next command when idle or on the last character of this one
		pop = qstat.valid && ((state_q == ST_IDLE) || (emit && (state_q == ST_LO)));
		if (pop) begin
			state_d = head_cmd.hdr ? ST_ZERO : ST_SPACE;
		end
	end

	// Command fields and counters
	always_ff @(posedge clk) begin
		if (pop) begin
			addr_q <= head_cmd.addr;
			data_q <= head_cmd.data;
			eol_q  <= head_cmd.eol;
			eod_q  <= head_cmd.eod;
			dig_q  <= DIG_BITS'(DUMP_DIGITS - 1);
			spc_q  <= head_spc;
		end else if (emit) begin
			if (state_q == ST_ADDR) begin
				dig_q <= dig_q - 1'b1;
			end
			if (state_q == ST_PAD) begin
				spc_q <= spc_q - 1'b1;
			end
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			char_q    <= char_d;
			out_eol_q <= eol_d;
			out_eod_q <= eod_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign character   = char_q;
	assign end_of_line = out_eol_q;
	assign end_of_dump = out_eod_q;

endmodule

>>> rtl/hdf_checker.sv
// ----------------------------------------------------------------------------
// hdf_checker
// Port-level checks on the hex dump formatter output stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hdf_checker import hdf_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [6:0]  character,
	input logic        end_of_line,
	input logic        end_of_dump
);

	logic out_take;
	logic char_legal;
	assign out_take = out_valid && !out_stall;

	// Space, colon, 'x', decimal digits and a..f
	assign char_legal = (character == CH_SPACE) || (character == CH_COLON)
		|| (character == CH_X)
		|| ((character >= CH_ZERO) && (character <= CH_ZERO + 7'd9))
		|| ((character >= CH_A_LC) && (character <= CH_A_LC + 7'd5));

	// End of dump always closes the line
	`ASSERT_IMPLY(a_eod_has_eol, clk, arst_n, out_valid && end_of_dump, end_of_line)

	// Only space, colon, digits, 'x' and a..f appear
	`ASSERT_IMPLY(a_char_set, clk, arst_n, out_valid, char_legal)

	// After a taken line end, a valid character is the '0' of the "0x" prefix
	`ASSERT_NEXT(a_line_opens_zero, clk, arst_n, out_take && end_of_line, !out_valid || (character == CH_ZERO))

	// Line marks only on a hex digit
	`ASSERT_IMPLY(a_eol_on_digit, clk, arst_n, out_valid && end_of_line, (character != CH_SPACE) && (character != CH_COLON) && (character != CH_X))

	// A stalled output character holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(character) && $stable(end_of_line) && $stable(end_of_dump))

endmodule

bind hex_dump_line_formatter hdf_checker u_hdf_checker (.*);

>>> test/hex_dump_line_formatter_test.sv
// ----------------------------------------------------------------------------
// hex_dump_line_formatter_test
// Drives byte items into the hex-dump formatter and checks every output
// character, with its end-of-line and end-of-dump flags, against a predictor
// of the dump text. Directed cases come first, then random dumps under three
// idle patterns on the input and output channels.
// ----------------------------------------------------------------------------
module hex_dump_line_formatter_test;
	import hdf_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int          DRAIN_CYCLES = 20;
	localparam int          MAX_PRINTED = 40;
	localparam logic [31:0] ADDR_MASK = 32'hffff_ffff >> (32 - ADDR_BITS);

	localparam logic [6:0] ASC_ZERO  = 7'h30;
	localparam logic [6:0] ASC_X     = 7'h78;
	localparam logic [6:0] ASC_COLON = 7'h3a;
	localparam logic [6:0] ASC_SPACE = 7'h20;

	// One character of the dump text with its flags
	typedef struct packed {
		logic [6:0] ch;
		logic       eol;
		logic       eod;
	} dump_char_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic [31:0] start_address = 32'h0;
	logic        first_byte = 1'b0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [6:0]  character;
	logic        end_of_line;
	logic        end_of_dump;

	dump_char_t  text_q[$];
	logic [31:0] next_addr = 32'h0;
	logic        line_active = 1'b0;
	string       hex_digits = "0123456789abcdef";
	int          sender_idle_pct = 0;
	int          receiver_idle_pct = 0;
	int          error_count = 0;
	int unsigned cycle_count = 0;

	hex_dump_line_formatter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.start_address (start_address),
		.first_byte    (first_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.character     (character),
		.end_of_line   (end_of_line),
		.end_of_dump   (end_of_dump)
	);

	always #5 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [6:0] nibble_ascii(input logic [3:0] nib);
		byte c;
		c = hex_digits[nib];
		return c[6:0];
	endfunction

	function automatic void push_char(input logic [6:0] c, input logic eol,
			input logic eod);
		dump_char_t e;
		e.ch = c;
		e.eol = eol;
		e.eod = eod;
		text_q.push_back(e);
	endfunction

	// Expected text for one accepted byte item
	function automatic void predict_text(input logic [7:0] d, input logic [31:0] a,
			input logic f, input logic l);
		logic [31:0] base;
		logic        closes;
		if (f) begin
			next_addr = a & ADDR_MASK;
			line_active = 1'b0;
		end
		// line header, padded up to the byte's column
		if (!line_active) begin
			base = {next_addr[31:4], 4'h0};
			push_char(ASC_ZERO, 1'b0, 1'b0);
			push_char(ASC_X, 1'b0, 1'b0);
			for (int i = 7; i >= 0; i--)
				push_char(nibble_ascii(base[4*i +: 4]), 1'b0, 1'b0);
			push_char(ASC_COLON, 1'b0, 1'b0);
			for (int i = 0; i < 3 * int'(next_addr[3:0]); i++)
				push_char(ASC_SPACE, 1'b0, 1'b0);
			line_active = 1'b1;
		end
		closes = l || (next_addr[3:0] == 4'hf);
		push_char(ASC_SPACE, 1'b0, 1'b0);
		push_char(nibble_ascii(d[7:4]), 1'b0, 1'b0);
		push_char(nibble_ascii(d[3:0]), closes, l);
		if (closes)
			line_active = 1'b0;
		next_addr = (next_addr + 32'd1) & ADDR_MASK;
	endfunction

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	// Output side: compare each accepted character, then pick the next stall
	always @(posedge clk) begin : text_check
		dump_char_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (text_q.size() == 0) begin
				report_mismatch($sformatf("unexpected character 0x%02h", character));
			end else begin
				e = text_q.pop_front();
				if (character !== e.ch)
					report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
						character, e.ch));
				if (end_of_line !== e.eol)
					report_mismatch($sformatf("end_of_line %b, expected %b",
						end_of_line, e.eol));
				if (end_of_dump !== e.eod)
					report_mismatch($sformatf("end_of_dump %b, expected %b",
						end_of_dump, e.eod));
			end
		end
		out_stall <= ($urandom_range(99) < receiver_idle_pct);
	end

	// Send one byte item; returns at the edge where it is accepted
	task automatic send_byte(input logic [7:0] d, input logic [31:0] a,
			input logic f, input logic l);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		start_address <= a;
		first_byte <= f;
		last_byte <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_text(d, a, f, l);
	endtask

	// Hold off input until every expected character has come out
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		while (text_q.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// Bytes before any first byte continue from address zero
	task automatic test_no_first_after_reset();
		send_byte(8'h00, 32'hdead_beef, 1'b0, 1'b0);
		send_byte(8'hff, 32'h0000_0000, 1'b0, 1'b0);
	endtask

	// A first byte abandons the open line; padded start, line wraps at offset 15
	task automatic test_first_inside_open_line();
		send_byte(8'h5a, 32'h1234_5678, 1'b1, 1'b0);
		for (int k = 0; k < 7; k++)
			send_byte(8'($urandom), $urandom, 1'b0, 1'b0);
		send_byte(8'h81, $urandom, 1'b0, 1'b0);
		send_byte(8'h7e, $urandom, 1'b0, 1'b1);
	endtask

	// One-byte dumps at the address extremes, then a byte after a finished dump
	task automatic test_one_byte_dumps();
		send_byte(8'hff, 32'hffff_ffff, 1'b1, 1'b1);
		send_byte(8'h00, 32'h0000_0000, 1'b1, 1'b1);
		send_byte(8'h96, 32'h0000_000f, 1'b1, 1'b1);
		send_byte(8'h42, 32'hffff_ffff, 1'b0, 1'b1);
	endtask

	// Address counter wraps from all ones to zero inside a dump
	task automatic test_address_wrap();
		send_byte(8'h11, 32'hffff_fffe, 1'b1, 1'b0);
		send_byte(8'h22, 32'h0, 1'b0, 1'b0);
		send_byte(8'h33, 32'h0, 1'b0, 1'b1);
	endtask

	// Mostly well-formed dumps of random length and content, plus broken
	// dumps without a last byte and items with random flags
	task automatic test_random_dumps(input int n_items, input int in_pct,
			input int out_pct);
		int          sent;
		int          len;
		int          kind;
		logic [31:0] addr;
		sender_idle_pct = in_pct;
		receiver_idle_pct = out_pct;
		hold_until_drained();
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(99);
			addr = ($urandom_range(3) == 0) ? (32'hffff_ffe0 | $urandom_range(31))
				: $urandom;
			len = ($urandom_range(7) == 0) ? $urandom_range(48, 17)
				: $urandom_range(16, 1);
			if (len > n_items - sent)
				len = n_items - sent;
			for (int k = 0; k < len; k++) begin
				if (kind < 80)
					send_byte(8'($urandom), (k == 0) ? addr : $urandom, k == 0,
						k == len - 1);
				else if (kind < 90)
					send_byte(8'($urandom), (k == 0) ? addr : $urandom, k == 0, 1'b0);
				else
					send_byte(8'($urandom), $urandom, $urandom_range(3) == 0,
						$urandom_range(3) == 0);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_no_first_after_reset();
		test_first_inside_open_line();
		test_one_byte_dumps();
		test_address_wrap();

		test_random_dumps(137, 20, 54);
		test_random_dumps(137, 54, 20);
		test_random_dumps(137, 0, 0);

		// wait out the last characters, then watch for stray ones
		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/hdf_pkg.sv
rtl/hdf_front.sv
rtl/hdf_queue.sv
rtl/hdf_back.sv
rtl/hex_dump_line_formatter.sv
rtl/hdf_checker.sv
test/hex_dump_line_formatter_test.sv
